// ----- rtl/brms_pkg.sv -----
package brms_pkg;

    localparam int SUM_W   = 44;
    localparam int BLK_W   = 13;
    localparam int FULL_W  = 15;
    localparam int CNT_W   = 14;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int HGT_W   = 16;
    localparam int OUT_W   = 72;

    localparam logic [1:0] REG_CHANNEL_MODE      = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT     = 2'd1;
    localparam logic [1:0] REG_SAMPLES_PER_PIXEL = 2'd2;
    localparam logic [1:0] REG_SAMPLE_WIDTH      = 2'd3;

    localparam logic [1:0] MODE_LEFT  = 2'd0;
    localparam logic [1:0] MODE_RIGHT = 2'd1;

    // one closed block waiting for level math
    typedef struct packed {
        logic [15:0]       column;
        logic [SUM_W-1:0]  lsum;
        logic [SUM_W-1:0]  rsum;
        logic [BLK_W-1:0]  block;
        logic [FULL_W-1:0] full;
        logic              stereo;
        logic              use_left;
    } t_job;

endpackage

// ----- rtl/block_rms_waveform_column_unit.sv -----
// Block RMS level meter producing one waveform column per audio block.
// Input stream: one word per audio frame, left and right samples. Frames are
// squared and summed per enabled lane, one frame per cycle.
// When the block count is reached the sums go to a two-entry job queue and
// the accumulators clear; the back end divides by block size, takes the
// floor square root, scales by 76 over full scale and formats the column.
// Output stream: one word per closed block (column index, heights, rows,
// flat flags).
// The back end works per lane through a 44-step divide, a 22-step root, one
// multiply and a 44-step scale divide, the two lanes in turn; both divides
// run on the shared bit-serial divider.
// Frames are taken one per cycle while the queue has room; with very short
// blocks the input is paced by the back end.
// Reset (synchronous, active low) restores register defaults and clears
// sums, counters, queue and output valid.
// A stalled output holds its word; the back end waits, the queue fills and
// then input tready drops. A partial block is never emitted.
// Configuration writes are meant for idle periods and apply at once.
module block_rms_waveform_column_unit #(
    parameter int MAX_BLOCK_SAMPLES = 8191,
    parameter int SAMPLE_BITS       = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] left_sample, [31:16] right_sample
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] column, [24:16] first_height, [33:25] second_height,
    // [42:34] first_top, [51:43] first_bottom, [60:52] second_top,
    // [69:61] second_bottom, [70] first_flat, [71] second_flat
    output logic [71:0] m_axis_tdata
);
    import brms_pkg::*;

    logic q_full, push, pop, q_valid;
    t_job job_in, job_out;

    brms_front #(
        .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_left(s_axis_tdata[15:0]), .i_right(s_axis_tdata[31:16]),
        .i_q_full(q_full), .o_push(push), .o_job(job_in)
    );

    brms_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_job(job_in), .o_full(q_full),
        .i_pop(pop), .o_valid(q_valid), .o_job(job_out)
    );

    brms_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_job(job_out), .o_pop(pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );

endmodule

// ----- rtl/brms_front.sv -----
module brms_front #(
    parameter int MAX_BLOCK_SAMPLES = 8191,
    parameter int SAMPLE_BITS       = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [12:0]   i_cfg_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_left,
    input  logic [15:0]   i_right,
    input  logic          i_q_full,
    output logic          o_push,
    output brms_pkg::t_job o_job
);
    import brms_pkg::*;

    logic [1:0]        r_mode, r_chan, r_width;
    logic [BLK_W-1:0]  r_spp;
    logic [SUM_W-1:0]  r_lsum, r_rsum;
    logic [CNT_W-1:0]  r_cnt;
    logic [15:0]       r_col;

    logic              acc, lane_l, lane_r, src_st, close;
    logic [BLK_W-1:0]  blk;
    logic [CNT_W-1:0]  cnt_nx;
    logic signed [16:0] vl, vr;
    logic [33:0]       sql, sqr;
    logic [SUM_W-1:0]  n_lsum, n_rsum;

    function automatic logic signed [16:0] samp(input logic [15:0] raw, input logic narrow);
        if (narrow) return {9'd0, raw[7:0]};
        return 17'($signed(raw[SAMPLE_BITS-1:0]));
    endfunction

    always_comb begin
        acc    = i_valid && o_ready;
        lane_l = (r_mode != MODE_RIGHT);
        lane_r = (r_mode != MODE_LEFT);
        src_st = (r_chan == 2'd2);
        if (r_spp == '0) begin
            blk = BLK_W'(1);
        end else if (32'(r_spp) > MAX_BLOCK_SAMPLES) begin
            blk = BLK_W'(MAX_BLOCK_SAMPLES);
        end else begin
            blk = r_spp;
        end
        vl  = samp(i_left, r_width == 2'd1);
        vr  = samp(i_right, r_width == 2'd1);
        sql = 34'(vl * vl);
        sqr = 34'(vr * vr);
        n_lsum = lane_l ? r_lsum + SUM_W'(sql[31:0]) : r_lsum;
        n_rsum = (lane_r && src_st) ? r_rsum + SUM_W'(sqr[31:0]) : r_rsum;
        cnt_nx = r_cnt + (src_st ? CNT_W'(2) : CNT_W'(1));
        close  = (cnt_nx >= {1'b0, blk});
    end

    assign o_ready = !i_q_full;
    assign o_push  = acc && close;

    always_comb begin
        o_job.column   = r_col;
        o_job.lsum     = n_lsum;
        o_job.rsum     = n_rsum;
        o_job.block    = blk;
        o_job.full     = FULL_W'((lane_l && lane_r) ? 15'h7F : 15'h3F)
                         << ((r_width == 2'd1) ? 0 : (SAMPLE_BITS - 8));
        o_job.stereo   = lane_l && lane_r;
        o_job.use_left = lane_l;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 2'd2;
            r_chan  <= 2'd2;
            r_spp   <= BLK_W'(1764);
            r_width <= 2'd2;
            r_lsum  <= '0;
            r_rsum  <= '0;
            r_cnt   <= '0;
            r_col   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_CHANNEL_MODE:      r_mode  <= i_cfg_data[1:0];
                    REG_CHANNEL_COUNT:     r_chan  <= i_cfg_data[1:0];
                    REG_SAMPLES_PER_PIXEL: r_spp   <= i_cfg_data;
                    REG_SAMPLE_WIDTH:      r_width <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (acc) begin
                if (close) begin
                    r_lsum <= '0;
                    r_rsum <= '0;
                    r_cnt  <= '0;
                    r_col  <= r_col + 16'd1;
                end else begin
                    r_lsum <= n_lsum;
                    r_rsum <= n_rsum;
                    r_cnt  <= cnt_nx;
                end
            end
        end
    end

endmodule

// ----- rtl/brms_queue.sv -----
module brms_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  brms_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output brms_pkg::t_job o_job
);
    import brms_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ----- rtl/brms_back.sv -----
module brms_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  brms_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [71:0]    o_data
);
    import brms_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_SQRT = 3'd2,
                           S_MUL = 3'd3, S_DIV2 = 3'd4, S_OUT = 3'd5;

    logic [2:0]        r_state;
    logic              r_lane;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_num;
    logic [24:0]       r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [FULL_W-1:0] r_div;
    logic [HGT_W-1:0]  r_h0;
    t_job              r_job;
    logic              r_ovalid;
    logic [71:0]       r_odata;

    logic [15:0]  dt;
    logic         dge;
    logic [24:0]  st, strial;
    logic         sge;
    logic         load;
    logic [HGT_W-1:0] hsel, h1;
    logic [8:0]   c0, c1;
    logic [71:0]  fmt;

    always_comb begin
        dt     = {r_rem[14:0], r_num[SUM_W-1]};
        dge    = (dt >= {1'b0, r_div});
        st     = {r_rem[22:0], r_num[SUM_W-1 -: 2]};
        strial = {1'b0, r_root, 2'b01};
        sge    = (st >= strial);
        load   = (r_state == S_OUT) && (!r_ovalid || i_ready);
    end

    // result formatting, right lane height comes straight from the divider
    always_comb begin
        h1   = r_num[HGT_W-1:0];
        hsel = r_job.use_left ? r_h0 : h1;
        c0   = r_job.stereo ? 9'd19 : 9'd38;
        c1   = 9'd51;
        fmt  = '0;
        fmt[15:0] = r_job.column;
        if (r_job.stereo) begin
            fmt[24:16] = r_h0[8:0];
            fmt[33:25] = h1[8:0];
            fmt[42:34] = c0 - r_h0[9:1];
            fmt[51:43] = c0 + r_h0[9:1];
            fmt[60:52] = c1 - h1[9:1];
            fmt[69:61] = c1 + h1[9:1];
            fmt[70]    = (r_h0 <= 16'd1);
            fmt[71]    = (h1 <= 16'd1);
        end else begin
            fmt[24:16] = hsel[8:0];
            fmt[42:34] = c0 - hsel[9:1];
            fmt[51:43] = c0 + hsel[9:1];
            fmt[70]    = (hsel <= 16'd1);
        end
    end

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (load) r_odata <= fmt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_lane   <= 1'b0;
        end else begin
            if (load)         r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_job   <= i_job;
                        r_num   <= i_job.lsum;
                        r_div   <= FULL_W'(i_job.block);
                        r_rem   <= '0;
                        r_step  <= STEP_W'(SUM_W - 1);
                        r_lane  <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV, S_DIV2: begin
                    r_rem  <= 25'(dge ? dt - {1'b0, r_div} : dt);
                    r_num  <= {r_num[SUM_W-2:0], dge};
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        if (r_state == S_DIV) begin
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_step  <= STEP_W'(ROOT_W - 1);
                            r_state <= S_SQRT;
                        end else if (!r_lane) begin
                            r_h0    <= HGT_W'({r_num[SUM_W-2:0], dge});
                            r_lane  <= 1'b1;
                            r_num   <= r_job.rsum;
                            r_div   <= FULL_W'(r_job.block);
                            r_rem   <= '0;
                            r_step  <= STEP_W'(SUM_W - 1);
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SQRT: begin
                    r_rem  <= sge ? st - strial : st;
                    r_root <= {r_root[ROOT_W-2:0], sge};
                    r_num  <= {r_num[SUM_W-3:0], 2'b00};
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_num   <= SUM_W'(r_root * 7'd76);
                    r_div   <= r_job.full;
                    r_rem   <= '0;
                    r_step  <= STEP_W'(SUM_W - 1);
                    r_state <= S_DIV2;
                end
                S_OUT: begin
                    if (load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/brms_checker.sv -----
module brms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    logic        r_seen;
    logic [15:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_col  <= '0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_seen <= 1'b1;
            r_col  <= m_axis_tdata[15:0];
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && r_seen |-> m_axis_tdata[15:0] == r_col + 16'd1)
        else $error("column index skipped");

    a_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[70] |-> m_axis_tdata[42:34] == m_axis_tdata[51:43])
        else $error("flat line with differing rows");

endmodule

bind block_rms_waveform_column_unit brms_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
